@@ design/tfb_pkg.sv @@
// ----------------------------------------------------------------------------
// tfb_pkg
// Shared types and constants for the telemetry frame builder.
// ----------------------------------------------------------------------------
package tfb_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 256;
  localparam int unsigned HDR_BYTES       = 4;
  localparam int unsigned MAX_RES         = HDR_BYTES + 1;  // header plus checksum
  localparam int unsigned CNT_W           = $clog2(MAX_RES + 1);

  localparam logic [15:0] CAP_RESET   = 16'd256;
  localparam logic [15:0] CAP_MIN     = 16'(MAX_FRAME_BYTES);
  localparam logic [15:0] PAYLOAD_MAX = 16'(MAX_FRAME_BYTES - HDR_BYTES);
  localparam logic [16:0] FRAME_OVHD  = 17'(HDR_BYTES + 1);

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_DATA  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_NO_FRAME = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
    status_e    status;
  } res_t;

  typedef res_t [MAX_RES-1:0] burst_t;
  typedef logic [CNT_W-1:0]   cnt_t;

endpackage

@@ design/tfb_core.sv @@
// ----------------------------------------------------------------------------
// tfb_core
// Frame state and per-request result generation (header, payload, checksum).
// ----------------------------------------------------------------------------
module tfb_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [15:0]     cfg_wdata_i,
  input  logic            fire_i,
  input  logic            func_i,
  input  logic [15:0]     packet_id_i,
  input  logic [15:0]     payload_length_i,
  input  logic [7:0]      data_byte_i,
  output tfb_pkg::burst_t burst_o,
  output tfb_pkg::cnt_t   cnt_o
);

  logic [15:0] cap_q;
  logic        open_q, open_d;
  logic [15:0] rem_q, rem_d;
  logic [7:0]  sum_q, sum_d;

  logic        overflow;
  logic [7:0]  hdr_sum;
  logic [7:0]  data_sum;
  logic [15:0] rem_dec;

  assign overflow = (cap_q < tfb_pkg::CAP_MIN) || (payload_length_i > tfb_pkg::PAYLOAD_MAX)
                 || (({1'b0, payload_length_i} + tfb_pkg::FRAME_OVHD) > {1'b0, cap_q});
  assign hdr_sum  = packet_id_i[15:8] + packet_id_i[7:0]
                  + payload_length_i[15:8] + payload_length_i[7:0];
  assign data_sum = sum_q + data_byte_i;
  assign rem_dec  = rem_q - 16'd1;

  always_comb begin
    burst_o = '0;
    cnt_o   = '0;
    open_d  = open_q;
    rem_d   = rem_q;
    sum_d   = sum_q;
    case (tfb_pkg::func_e'(func_i))
      tfb_pkg::FUNC_START: begin
        open_d = 1'b0;
        rem_d  = '0;
        sum_d  = '0;
        if (overflow) begin
          burst_o[0] = '{frame_byte: 8'd0, frame_end: 1'b1, status: tfb_pkg::ST_OVERFLOW};
          cnt_o      = tfb_pkg::cnt_t'(1);
        end else begin
          burst_o[0] = '{frame_byte: packet_id_i[15:8], frame_end: 1'b0,
                         status: tfb_pkg::ST_OK};
          burst_o[1] = '{frame_byte: packet_id_i[7:0], frame_end: 1'b0,
                         status: tfb_pkg::ST_OK};
          burst_o[2] = '{frame_byte: payload_length_i[15:8], frame_end: 1'b0,
                         status: tfb_pkg::ST_OK};
          burst_o[3] = '{frame_byte: payload_length_i[7:0], frame_end: 1'b0,
                         status: tfb_pkg::ST_OK};
          if (payload_length_i == 16'd0) begin
            // empty payload: checksum follows the header at once
            burst_o[4] = '{frame_byte: hdr_sum, frame_end: 1'b1, status: tfb_pkg::ST_OK};
            cnt_o      = tfb_pkg::cnt_t'(tfb_pkg::MAX_RES);
          end else begin
            open_d = 1'b1;
            rem_d  = payload_length_i;
            sum_d  = hdr_sum;
            cnt_o  = tfb_pkg::cnt_t'(tfb_pkg::HDR_BYTES);
          end
        end
      end
      default: begin
        if (!open_q) begin
          burst_o[0] = '{frame_byte: 8'd0, frame_end: 1'b1, status: tfb_pkg::ST_NO_FRAME};
          cnt_o      = tfb_pkg::cnt_t'(1);
        end else begin
          burst_o[0] = '{frame_byte: data_byte_i, frame_end: 1'b0, status: tfb_pkg::ST_OK};
          if (rem_dec == 16'd0) begin
            burst_o[1] = '{frame_byte: data_sum, frame_end: 1'b1, status: tfb_pkg::ST_OK};
            cnt_o      = tfb_pkg::cnt_t'(2);
            open_d     = 1'b0;
            rem_d      = '0;
            sum_d      = '0;
          end else begin
            cnt_o = tfb_pkg::cnt_t'(1);
            rem_d = rem_dec;
            sum_d = data_sum;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= tfb_pkg::CAP_RESET;
      open_q <= 1'b0;
      rem_q  <= '0;
      sum_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (fire_i) begin
        open_q <= open_d;
        rem_q  <= rem_d;
        sum_q  <= sum_d;
      end
    end
  end

endmodule

@@ design/tfb_out.sv @@
// ----------------------------------------------------------------------------
// tfb_out
// Result register: holds one request's burst and sends it a byte per beat.
// ----------------------------------------------------------------------------
module tfb_out (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  tfb_pkg::burst_t burst_i,
  input  tfb_pkg::cnt_t   cnt_i,
  output logic            can_load_o,
  output logic            valid_o,
  input  logic            ready_i,
  output tfb_pkg::res_t   res_o
);

  tfb_pkg::burst_t burst_q;
  tfb_pkg::cnt_t   cnt_q;
  tfb_pkg::cnt_t   idx_q;
  logic            busy_q;
  logic            last_beat;

  assign last_beat  = (idx_q == (cnt_q - tfb_pkg::cnt_t'(1)));
  assign can_load_o = !busy_q || (ready_i && last_beat);
  assign valid_o    = busy_q;
  assign res_o      = burst_q[idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      idx_q  <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      cnt_q  <= cnt_i;
      idx_q  <= '0;
    end else if (busy_q && ready_i) begin
      if (last_beat) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + tfb_pkg::cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      burst_q <= burst_i;
    end
  end

endmodule

@@ design/telemetry_frame_builder.sv @@
// ----------------------------------------------------------------------------
// telemetry_frame_builder
// Length-prefixed telemetry frame builder with modulo-256 checksum.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream takes requests: tuser is the kind (0 start, 1 payload byte),
//   tdata carries packet id, payload length and payload byte. A start request
//   yields the big-endian header (id, length) and, for an empty payload, the
//   checksum straight after; each payload byte is passed through and the last
//   one is followed by the checksum (tlast). A rejected start or a stray byte
//   gives one zero byte with tlast set and an error code in tuser.
//   Master stream sends one frame byte per beat, tuser = status.
//   Output: the first byte of a request appears in the cycle after acceptance.
//   Bursts: a request makes as many output beats as its burst holds
//   (1 for a payload byte or an error, 2 on the closing byte, 4 or 5 for a
//   start); the result register is the only limit, and a new request is
//   taken in the cycle its last beat leaves.
//   Stall: while the receiver holds tready low the result register holds its
//   beat and s_axis_tready stays low until the last beat of the burst leaves.
//   Reset: no frame open, checksum cleared, out_capacity = 256, no output.
//   cfg_we_i writes out_capacity; write it only while the block is idle.
// ----------------------------------------------------------------------------
module telemetry_frame_builder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [15:0] packet_id, [31:16] payload_length,
                                      // [39:32] data_byte
  input  logic        s_axis_tuser,   // [0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] frame_byte
  output logic        m_axis_tlast,   // frame_end
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  logic            fire;
  logic            can_load;
  tfb_pkg::burst_t burst;
  tfb_pkg::cnt_t   cnt;
  tfb_pkg::res_t   res;

  // request accepted when the result register frees up this cycle
  assign s_axis_tready = can_load;
  assign fire          = s_axis_tvalid && can_load;

  tfb_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .fire_i           (fire),
    .func_i           (s_axis_tuser),
    .packet_id_i      (s_axis_tdata[15:0]),
    .payload_length_i (s_axis_tdata[31:16]),
    .data_byte_i      (s_axis_tdata[39:32]),
    .burst_o          (burst),
    .cnt_o            (cnt)
  );

  tfb_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (fire),
    .burst_i    (burst),
    .cnt_i      (cnt),
    .can_load_o (can_load),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .res_o      (res)
  );

  assign m_axis_tdata = res.frame_byte;
  assign m_axis_tlast = res.frame_end;
  assign m_axis_tuser = res.status;

endmodule

@@ tb/tb_telemetry_frame_builder.sv @@
// ----------------------------------------------------------------------------
// tb_telemetry_frame_builder
// Self-checking bench for the telemetry frame builder. A short directed table
// covers reset, header extremes, rejected starts, abandoned and empty frames
// and stray payload bytes. Randomised frame sequences then run under several
// out_capacity settings and back-pressure mixes. Every output beat is checked
// against an in-bench frame predictor or the fixed result of its table row.
// ----------------------------------------------------------------------------
module tb_telemetry_frame_builder;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no handshake on either side before the run is abandoned.
  localparam int unsigned QUIET_LIMIT = 2000;

  localparam tfb_pkg::res_t OVERFLOW_RES = '{frame_byte: 8'h00, frame_end: 1'b1,
                                             status: tfb_pkg::ST_OVERFLOW};
  localparam tfb_pkg::res_t NO_FRAME_RES = '{frame_byte: 8'h00, frame_end: 1'b1,
                                             status: tfb_pkg::ST_NO_FRAME};

  typedef struct {
    tfb_pkg::func_e kind;
    logic [15:0]    packet_id;
    logic [15:0]    body_len;
    logic [7:0]     data_byte;
  } request_t;

  // One row of the directed table; fixed rows carry their result by hand.
  typedef struct {
    request_t      req;
    bit            fixed;
    tfb_pkg::res_t res;
  } table_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [15:0] cfg_wdata_i   = 16'h0000;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;   // [15:0] packet_id, [31:16] payload_length,
                                     // [39:32] data_byte
  logic        s_axis_tuser  = 1'b0; // [0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // [7:0] frame_byte
  logic        m_axis_tlast;         // frame_end
  logic [1:0]  m_axis_tuser;         // [1:0] status

  // Shadow of the block state, advanced once per accepted request.
  logic [15:0] capacity     = tfb_pkg::CAP_RESET;
  logic        open_frame   = 1'b0;
  logic [15:0] payload_left = '0;
  logic [7:0]  sum_so_far   = '0;

  tfb_pkg::res_t pending_bytes_q[$];   // frame bytes still owed by the block
  table_row_t    directed_rows[$];

  int unsigned idle_pct  = 0;        // sender gap chance, percent
  int unsigned stall_pct = 0;        // receiver stall chance, percent

  int unsigned mismatches    = 0;
  int unsigned requests_sent = 0;
  int unsigned beats_checked = 0;
  int unsigned frames_closed = 0;
  int unsigned starts_denied = 0;
  int unsigned stray_bytes   = 0;
  int unsigned cap_settings  = 0;
  int unsigned quiet_cycles  = 0;

  telemetry_frame_builder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Frame predictor
  // --------------------------------------------------------------------------
  function automatic void queue_byte(logic [7:0] b, logic last, tfb_pkg::status_e st);
    tfb_pkg::res_t r;
    r.frame_byte = b;
    r.frame_end  = last;
    r.status     = st;
    pending_bytes_q.push_back(r);
  endfunction

  // Advances the shadow state for one request; with record set, queues the
  // frame bytes it should produce.
  function automatic void next_frame_bytes(request_t req, bit record);
    logic [tfb_pkg::HDR_BYTES-1:0][7:0] hdr;
    int unsigned                        frame_len;
    if (req.kind == tfb_pkg::FUNC_START) begin
      // any open frame is dropped without a checksum
      open_frame   = 1'b0;
      payload_left = '0;
      sum_so_far   = '0;
      frame_len    = tfb_pkg::HDR_BYTES + req.body_len + 1;
      if (capacity < tfb_pkg::MAX_FRAME_BYTES
          || req.body_len > tfb_pkg::MAX_FRAME_BYTES - tfb_pkg::HDR_BYTES
          || frame_len > capacity) begin
        if (record) pending_bytes_q.push_back(OVERFLOW_RES);
      end else begin
        hdr = {req.packet_id, req.body_len};   // big-endian: id high first
        for (int i = tfb_pkg::HDR_BYTES - 1; i >= 0; i--) begin
          sum_so_far += hdr[i];
          if (record) queue_byte(hdr[i], 1'b0, tfb_pkg::ST_OK);
        end
        if (req.body_len == 0) begin
          // empty payload closes straight away
          if (record) queue_byte(sum_so_far, 1'b1, tfb_pkg::ST_OK);
          sum_so_far = '0;
        end else begin
          open_frame   = 1'b1;
          payload_left = req.body_len;
        end
      end
    end else if (!open_frame) begin
      if (record) pending_bytes_q.push_back(NO_FRAME_RES);
    end else begin
      sum_so_far += req.data_byte;
      if (record) queue_byte(req.data_byte, 1'b0, tfb_pkg::ST_OK);
      payload_left--;
      if (payload_left == 0) begin
        if (record) queue_byte(sum_so_far, 1'b1, tfb_pkg::ST_OK);
        open_frame = 1'b0;
        sum_so_far = '0;
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Unused fields are filled with noise so every tdata bit toggles.
  function automatic request_t make_request(tfb_pkg::func_e kind, logic [15:0] len);
    request_t r;
    r.kind      = kind;
    r.packet_id = 16'($urandom_range(65535));
    r.body_len  = len;
    r.data_byte = 8'($urandom_range(255));
    return r;
  endfunction

  function automatic void add_row(tfb_pkg::func_e kind, logic [15:0] id, logic [15:0] len,
                                  logic [7:0] b, bit fixed = 1'b0,
                                  tfb_pkg::res_t res = '0);
    table_row_t row;
    row.req.kind      = kind;
    row.req.packet_id = id;
    row.req.body_len  = len;
    row.req.data_byte = b;
    row.fixed         = fixed;
    row.res           = res;
    directed_rows.push_back(row);
  endfunction

  // Drives one request and waits for the handshake. tvalid is only lowered
  // when a gap is taken, so it never toggles within one step.
  task automatic send_request(input request_t req, input bit fixed,
                              input tfb_pkg::res_t fixed_res);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {req.data_byte, req.body_len, req.packet_id};
    s_axis_tuser  <= req.kind;
    do @(posedge clk_i); while (!s_axis_tready);
    next_frame_bytes(req, !fixed);
    if (fixed) pending_bytes_q.push_back(fixed_res);
    requests_sent++;
  endtask

  // Block must be idle for a register write: drain, settle, then write.
  task automatic set_capacity(input logic [15:0] value);
    while (pending_bytes_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    capacity = value;
    cap_settings++;
  endtask

  // Mostly well-formed frames with random content; some truncated frames,
  // stray bytes and starts with wild lengths mixed in.
  task automatic random_frames(input int unsigned n_items);
    int unsigned   done_items;
    int unsigned   pick;
    int unsigned   len;
    int unsigned   cut;
    int unsigned   limit;
    tfb_pkg::res_t none;
    none       = '0;
    done_items = 0;
    // largest payload that still fits under the current capacity
    limit = tfb_pkg::MAX_FRAME_BYTES - tfb_pkg::HDR_BYTES;
    if (capacity >= tfb_pkg::MAX_FRAME_BYTES && capacity - tfb_pkg::HDR_BYTES - 1 < limit)
      limit = capacity - tfb_pkg::HDR_BYTES - 1;
    while (done_items < n_items) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        send_request(make_request(tfb_pkg::FUNC_DATA, 16'($urandom_range(65535))),
                     1'b0, none);
        done_items++;
      end else if (pick < 12) begin
        send_request(make_request(tfb_pkg::FUNC_START, 16'($urandom_range(65535))),
                     1'b0, none);
        done_items++;
      end else begin
        pick = $urandom_range(99);
        if (pick < 60) len = $urandom_range(6);
        else if (pick < 97) len = $urandom_range(40, 7);
        else begin
          case ($urandom_range(2))
            0:       len = limit;
            1:       len = limit + 1;
            default: len = tfb_pkg::MAX_FRAME_BYTES - tfb_pkg::HDR_BYTES;
          endcase
        end
        if (len > 40) cut = ($urandom_range(3) == 0) ? len : $urandom_range(8);
        else if (len > 0 && $urandom_range(99) < 8) cut = $urandom_range(len - 1);
        else cut = len;
        // a rejected start would turn the payload into a long run of strays
        if ((capacity < tfb_pkg::MAX_FRAME_BYTES || len > limit) && cut > 3) cut = 3;
        send_request(make_request(tfb_pkg::FUNC_START, 16'(len)), 1'b0, none);
        repeat (cut)
          send_request(make_request(tfb_pkg::FUNC_DATA, 16'($urandom_range(65535))),
                       1'b0, none);
        done_items += cut + 1;
      end
    end
  endtask

  task automatic run_phase(input logic [15:0] cap, input int unsigned s_idle,
                           input int unsigned r_stall, input int unsigned n_items);
    set_capacity(cap);
    idle_pct  = s_idle;
    stall_pct = r_stall;
    random_frames(n_items);
    s_axis_tvalid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Frame byte side: back-pressure and checking
  // --------------------------------------------------------------------------
  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk_i) begin
    tfb_pkg::res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      beats_checked++;
      if (pending_bytes_q.size() == 0) begin
        $display("%0t: frame byte with nothing owed: byte %02h last %0b status %0d",
                 $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
        mismatches++;
      end else begin
        want = pending_bytes_q.pop_front();
        if (m_axis_tdata !== want.frame_byte) begin
          $display("%0t: frame_byte expected %02h, got %02h",
                   $time, want.frame_byte, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tlast !== want.frame_end) begin
          $display("%0t: frame_end expected %0b, got %0b", $time, want.frame_end, m_axis_tlast);
          mismatches++;
        end
        if (m_axis_tuser !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, m_axis_tuser);
          mismatches++;
        end
      end
      if (m_axis_tlast) begin
        case (m_axis_tuser)
          tfb_pkg::ST_OK:       frames_closed++;
          tfb_pkg::ST_OVERFLOW: starts_denied++;
          tfb_pkg::ST_NO_FRAME: stray_bytes++;
          default:              ;
        endcase
      end
    end
  end

  // Watchdog: any handshake on either side resets the count.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no traffic for %0d cycles, %0d frame bytes still owed",
               $time, QUIET_LIMIT, pending_bytes_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    // Directed table, reset capacity of 256 (largest payload that fits: 251).
    add_row(tfb_pkg::FUNC_DATA,  16'hFFFF, 16'hFFFF, 8'hA5, 1'b1, NO_FRAME_RES); // stray
    add_row(tfb_pkg::FUNC_START, 16'hFFFF, 16'h0000, 8'hFF);                     // empty
    add_row(tfb_pkg::FUNC_START, 16'h0000, 16'h0000, 8'h00);
    add_row(tfb_pkg::FUNC_START, 16'h1234, 16'h00FD, 8'h00, 1'b1, OVERFLOW_RES); // too long
    add_row(tfb_pkg::FUNC_START, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, OVERFLOW_RES);
    add_row(tfb_pkg::FUNC_START, 16'h5A5A, 16'h00FC, 8'h00, 1'b1, OVERFLOW_RES); // no checksum
    add_row(tfb_pkg::FUNC_START, 16'hABCD, 16'h00FB, 8'h00);                     // largest
    add_row(tfb_pkg::FUNC_DATA,  16'h0000, 16'h0000, 8'h00);
    add_row(tfb_pkg::FUNC_DATA,  16'hFFFF, 16'hFFFF, 8'hFF);
    add_row(tfb_pkg::FUNC_START, 16'h8001, 16'h0002, 8'h00);                     // abandons
    add_row(tfb_pkg::FUNC_DATA,  16'h0000, 16'h0000, 8'hFF);
    add_row(tfb_pkg::FUNC_DATA,  16'h0000, 16'h0000, 8'hFF);                     // closes
    add_row(tfb_pkg::FUNC_DATA,  16'h0000, 16'h0000, 8'h55, 1'b1, NO_FRAME_RES);
    add_row(tfb_pkg::FUNC_START, 16'h00FF, 16'h0001, 8'h00);
    add_row(tfb_pkg::FUNC_DATA,  16'h0000, 16'h0000, 8'h80);
    add_row(tfb_pkg::FUNC_START, 16'hFF00, 16'h0003, 8'h00);
    add_row(tfb_pkg::FUNC_DATA,  16'h0000, 16'h0000, 8'h01);
    add_row(tfb_pkg::FUNC_START, 16'h0000, 16'h0000, 8'h00);                     // to empty
    add_row(tfb_pkg::FUNC_DATA,  16'h0000, 16'h0000, 8'h7E, 1'b1, NO_FRAME_RES);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].res);
    s_axis_tvalid <= 1'b0;

    //        capacity    gap  stall  items
    run_phase(16'd256,     0,   0,    50);
    run_phase(16'd65535,  83,   0,    60);
    run_phase(16'd0,       0,  83,    30);   // every start refused
    run_phase(16'd257,    35,  35,    50);
    run_phase(16'd255,     0,   0,    20);   // one short of the minimum
    run_phase(16'd300,     0,  83,    50);
    run_phase(16'd65535,  35,  35,    50);

    while (pending_bytes_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d requests over %0d capacity settings; checked %0d frame bytes.",
             requests_sent, cap_settings + 1, beats_checked);
    $display("Frames closed %0d, starts refused %0d, stray payload bytes %0d.",
             frames_closed, starts_denied, stray_bytes);
    if (mismatches == 0 && pending_bytes_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/tfb_pkg.sv
design/tfb_core.sv
design/tfb_out.sv
design/telemetry_frame_builder.sv
tb/tb_telemetry_frame_builder.sv
